FILE: design/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Bodies sample on clock and are disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define AST_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed: always");

// Antecedent implies consequent in the same cycle.
`define AST_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Antecedent implies consequent in the next cycle.
`define AST_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle");

`endif

FILE: design/fbfa_pkg.sv
// Shared types and constants of the first/best fit allocator.
// No dependencies; imported by every allocator module.
`default_nettype none

package fbfa_pkg;

   localparam int ADDR_W = 16;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_TOO_LARGE = 3'd1,
      STAT_NO_FIT    = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_FULL      = 3'd4
   } status_type;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic {
      CSR_MEMORY_SIZE  = 1'b0,
      CSR_FIT_STRATEGY = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INIT,
      OP_SAVE,
      OP_RESTORE,
      OP_ROTATE,
      OP_INSERT,
      OP_CARVE
   } cell_op_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_ASCAN,
      S_ADONE,
      S_FSAVE,
      S_FSCAN,
      S_FDONE
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] len;
   } extent_type;

   // Command broadcast along the cell row.
   typedef struct packed {
      cell_op_type       op;
      logic [ADDR_W-1:0] s;        // region / carve start
      logic [ADDR_W-1:0] l;        // region / carve length
      logic [ADDR_W-1:0] e;        // s + l
      logic              remove;   // carve exhausts the extent
      logic              any_left; // some cell ends at s
      logic              any_right;// some cell starts at e
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: design/first_best_fit_allocator.sv
// Top level of the first/best fit region allocator.
// Depends on fbfa_pkg, fbfa_chain (fbfa_cell) and assert_macros.svh.
//
//   channel | direction | tdata / tuser contents
//   req_    | in        | tdata: owner_id[15:0], request_bytes[31:16]; tuser: action
//   rsp_    | out       | tdata: status[2:0], start_address[18:3], length[34:19]
//   csr_    | in        | write enable, index (0 memory_size, 1 fit_strategy), data
//
// One transaction at a time. An allocate steps through accept, one full rotation
// of the row past the head comparator, and result; a free steps through accept,
// row save, registered region-table reads with one insert per hit, and result.
// After reset the row is loaded in the INIT state before req_tready rises.
// The result sits in an output register; a stalled rsp_ holds the finishing
// step until the register drains. A memory_size write reloads the pool.
`default_nettype none

module first_best_fit_allocator
   import fbfa_pkg::*;
#(
   parameter int FREE_ENTRIES   = 16,
   parameter int REGION_ENTRIES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // owner_id, request_bytes
   input  wire logic        req_tuser,   // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // status, start_address, length, zero pad
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   `include "assert_macros.svh"

   localparam int CELLS = FREE_ENTRIES + REGION_ENTRIES;
   localparam int KW    = $clog2(CELLS + 1);
   localparam int CW    = $clog2(CELLS + 1);
   localparam int RI    = $clog2(REGION_ENTRIES);

   // control
   state_type state_ff, state_in;
   logic [KW-1:0] kcnt_ff, kcnt_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] saved_ff, saved_in;
   logic [REGION_ENTRIES-1:0] rvalid_ff, rvalid_in;
   logic [REGION_ENTRIES-1:0] pend_ff, pend_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rd_v_ff, rd_v_in;

   // payload
   action_type        act_ff, act_in;
   logic [15:0]       owner_ff, owner_in;
   logic [15:0]       size_ff, size_in;
   logic [15:0]       memsize_ff, memsize_in;
   logic              fit_ff, fit_in;
   logic [RI-1:0]     slot_ff, slot_in;
   logic              slot_found_ff, slot_found_in;
   logic [ADDR_W-1:0] pick_start_ff, pick_start_in;
   logic [ADDR_W-1:0] pick_len_ff, pick_len_in;
   logic              found_ff, found_in;
   logic              any_ff, any_in;
   logic [15:0]       total_ff, total_in;
   logic [39:0]       rsp_data_ff, rsp_data_in;
   logic [RI-1:0]     rd_k_ff;
   logic [15:0]       rd_owner_ff, rd_start_ff, rd_len_ff;

   // region table
   logic [15:0] mem_owner [REGION_ENTRIES];
   logic [15:0] mem_start [REGION_ENTRIES];
   logic [15:0] mem_len   [REGION_ENTRIES];
   logic        mem_we;

   cell_ctl_type ctl;
   extent_type   head;
   logic         any_left, any_right;
   logic         accept, out_free, hit, head_fits, last_scan;
   status_type   astat;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_scan  = (kcnt_ff == KW'(CELLS - 1));
   assign hit        = rd_v_ff && rvalid_ff[rd_k_ff] && (rd_owner_ff == owner_ff);
   assign head_fits  = (head.len != '0) && (head.len >= size_ff);

   fbfa_chain #(.CELLS(CELLS)) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .head      (head),
      .any_left  (any_left),
      .any_right (any_right)
   );

   // allocate outcome; checks in order too large, zero, table full, no fit
   always_comb begin
      priority if (size_ff > memsize_ff) begin
         astat = STAT_TOO_LARGE;
      end else if (size_ff == '0) begin
         astat = STAT_NO_FIT;
      end else if (!slot_found_ff) begin
         astat = STAT_FULL;
      end else if (!found_ff) begin
         astat = STAT_NO_FIT;
      end else begin
         astat = STAT_OK;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               state_in = (action_type'(req_tuser) == ACT_FREE) ? S_FSAVE : S_ASCAN;
            end
         end
         S_ASCAN: if (last_scan) state_in = S_ADONE;
         S_ADONE: if (out_free) state_in = S_IDLE;
         S_FSAVE: state_in = S_FSCAN;
         S_FSCAN: if (kcnt_ff == KW'(REGION_ENTRIES)) state_in = S_FDONE;
         S_FDONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_INIT;
      endcase
   end

   // datapath and row commands
   always_comb begin
      ctl           = '0;
      ctl.op        = OP_HOLD;
      kcnt_in       = kcnt_ff;
      count_in      = count_ff;
      saved_in      = saved_ff;
      rvalid_in     = rvalid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      act_in        = act_ff;
      owner_in      = owner_ff;
      size_in       = size_ff;
      memsize_in    = memsize_ff;
      fit_in        = fit_ff;
      slot_in       = slot_ff;
      slot_found_in = slot_found_ff;
      pick_start_in = pick_start_ff;
      pick_len_in   = pick_len_ff;
      found_in      = found_ff;
      any_in        = any_ff;
      total_in      = total_ff;
      rd_v_in       = 1'b0;
      mem_we        = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            ctl.op   = OP_INIT;
            ctl.l    = memsize_ff;
            count_in = CW'(memsize_ff != '0);
         end
         S_IDLE: begin
            if (accept) begin
               act_in        = action_type'(req_tuser);
               owner_in      = req_tdata[15:0];
               size_in       = req_tdata[31:16];
               kcnt_in       = '0;
               slot_found_in = 1'b0;
               found_in      = 1'b0;
               any_in        = 1'b0;
               total_in      = '0;
               pend_in       = '0;
            end
         end
         S_ASCAN: begin
            // row rotates; cell k passes the head this cycle
            ctl.op  = OP_ROTATE;
            kcnt_in = KW'(kcnt_ff + 1'b1);
            if ((kcnt_ff < KW'(REGION_ENTRIES)) && !slot_found_ff
                  && !rvalid_ff[kcnt_ff[RI-1:0]]) begin
               slot_found_in = 1'b1;
               slot_in       = kcnt_ff[RI-1:0];
            end
            if (head_fits && (!found_ff || (fit_ff && (head.len < pick_len_ff)))) begin
               found_in      = 1'b1;
               pick_start_in = head.start;
               pick_len_in   = head.len;
            end
         end
         S_ADONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (astat == STAT_OK) begin
                  ctl.op     = OP_CARVE;
                  ctl.s      = pick_start_ff;
                  ctl.l      = size_ff;
                  ctl.remove = (pick_len_ff == size_ff);
                  if (pick_len_ff == size_ff) begin
                     count_in = CW'(count_ff - 1'b1);
                  end
                  mem_we             = 1'b1;
                  rvalid_in[slot_ff] = 1'b1;
                  rsp_data_in = {5'b0, size_ff, pick_start_ff, STAT_OK};
               end else begin
                  rsp_data_in = {5'b0, 16'b0, 16'b0, astat};
               end
            end
         end
         S_FSAVE: begin
            ctl.op   = OP_SAVE;
            saved_in = count_ff;
         end
         S_FSCAN: begin
            if (kcnt_ff < KW'(REGION_ENTRIES)) begin
               rd_v_in = 1'b1;
               kcnt_in = KW'(kcnt_ff + 1'b1);
            end
            if (hit) begin
               ctl.op           = OP_INSERT;
               ctl.s            = rd_start_ff;
               ctl.l            = rd_len_ff;
               ctl.e            = ADDR_W'(rd_start_ff + rd_len_ff);
               any_in           = 1'b1;
               total_in         = 16'(total_ff + rd_len_ff);
               pend_in[rd_k_ff] = 1'b1;
               // merge on both sides drops an extent, no merge adds one
               if (any_left && any_right) begin
                  count_in = CW'(count_ff - 1'b1);
               end else if (!any_left && !any_right) begin
                  count_in = CW'(count_ff + 1'b1);
               end
            end
         end
         S_FDONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               priority if (!any_ff) begin
                  rsp_data_in = {5'b0, 16'b0, 16'b0, STAT_NOT_FOUND};
               end else if (count_ff > CW'(FREE_ENTRIES)) begin
                  ctl.op      = OP_RESTORE;
                  count_in    = saved_ff;
                  rsp_data_in = {5'b0, 16'b0, 16'b0, STAT_FULL};
               end else begin
                  rvalid_in   = rvalid_ff & ~pend_ff;
                  rsp_data_in = {5'b0, total_ff, 16'b0, STAT_OK};
               end
            end
         end
         default: begin
         end
      endcase

      // register writes must arrive only while idle; the block itself does not enforce it
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MEMORY_SIZE: begin
               memsize_in = csr_wdata;
               ctl        = '0;
               ctl.op     = OP_INIT;
               ctl.l      = csr_wdata;
               count_in   = CW'(csr_wdata != '0);
               rvalid_in  = '0;
            end
            CSR_FIT_STRATEGY: fit_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         kcnt_ff      <= '0;
         count_ff     <= '0;
         rvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rd_v_ff      <= 1'b0;
         memsize_ff   <= 16'd1000;
         fit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kcnt_ff      <= kcnt_in;
         count_ff     <= count_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_v_ff      <= rd_v_in;
         memsize_ff   <= memsize_in;
         fit_ff       <= fit_in;
      end
      saved_ff      <= saved_in;
      pend_ff       <= pend_in;
      rsp_data_ff   <= rsp_data_in;
      act_ff        <= act_in;
      owner_ff      <= owner_in;
      size_ff       <= size_in;
      slot_ff       <= slot_in;
      slot_found_ff <= slot_found_in;
      pick_start_ff <= pick_start_in;
      pick_len_ff   <= pick_len_in;
      found_ff      <= found_in;
      any_ff        <= any_in;
      total_ff      <= total_in;
   end

   // region table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_owner[slot_ff] <= owner_ff;
         mem_start[slot_ff] <= pick_start_ff;
         mem_len[slot_ff]   <= size_ff;
      end
      rd_owner_ff <= mem_owner[kcnt_ff[RI-1:0]];
      rd_start_ff <= mem_start[kcnt_ff[RI-1:0]];
      rd_len_ff   <= mem_len[kcnt_ff[RI-1:0]];
      rd_k_ff     <= kcnt_ff[RI-1:0];
   end

   `AST_ALWAYS(a_count_cap, count_ff <= CW'(CELLS))
   `AST_IMPLY(a_idle_fits, state_ff == S_IDLE, count_ff <= CW'(FREE_ENTRIES))
   `AST_NEXT(a_alloc_len, (state_ff == S_ADONE) && out_free && (astat == STAT_OK)
      && (act_ff == ACT_ALLOC), rsp_tdata[34:19] == $past(size_ff))

endmodule

`default_nettype wire

FILE: design/fbfa_cell.sv
// One free-extent cell of the allocator row: working and saved copy.
// Depends on fbfa_pkg; instantiated by fbfa_chain.
`default_nettype none

module fbfa_cell
   import fbfa_pkg::*;
#(
   parameter bit HEAD = 1'b0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire extent_type   prev,
   input  wire extent_type   next,
   input  wire logic         prev_gt,
   output extent_type        cur,
   output logic              gt,
   output logic              ml,
   output logic              mr
);

   extent_type cur_ff, cur_in;
   extent_type sav_ff, sav_in;
   logic [ADDR_W-1:0] cur_end;
   logic              live;
   logic              ge_e;
   logic              ge_s;

   assign cur     = cur_ff;
   assign live    = (cur_ff.len != '0);
   assign cur_end = ADDR_W'(cur_ff.start + cur_ff.len);
   assign ml      = live && (cur_end == ctl.s);
   assign mr      = live && (cur_ff.start == ctl.e);
   assign gt      = !live || (cur_ff.start > ctl.s);
   assign ge_e    = !live || (cur_ff.start >= ctl.e);
   assign ge_s    = !live || (cur_ff.start >= ctl.s);

   always_comb begin
      cur_in = cur_ff;
      sav_in = sav_ff;
      unique case (ctl.op)
         OP_HOLD: begin
         end
         OP_INIT: begin
            cur_in.start = '0;
            cur_in.len   = HEAD ? ctl.l : '0;
         end
         OP_SAVE: begin
            sav_in = cur_ff;
         end
         OP_RESTORE: begin
            cur_in = sav_ff;
         end
         OP_ROTATE: begin
            cur_in = next;
         end
         OP_INSERT: begin
            if (ctl.any_left && ctl.any_right) begin
               // region bridges two extents; the row closes up behind
               if (ml) begin
                  cur_in.len = ADDR_W'(cur_ff.len + ctl.l + next.len);
               end else if (ge_e) begin
                  cur_in = next;
               end
            end else if (ctl.any_left) begin
               if (ml) begin
                  cur_in.len = ADDR_W'(cur_ff.len + ctl.l);
               end
            end else if (ctl.any_right) begin
               if (mr) begin
                  cur_in.start = ctl.s;
                  cur_in.len   = ADDR_W'(cur_ff.len + ctl.l);
               end
            end else if (gt) begin
               // sorted insert: first greater cell takes the region
               if (prev_gt) begin
                  cur_in = prev;
               end else begin
                  cur_in.start = ctl.s;
                  cur_in.len   = ctl.l;
               end
            end
         end
         OP_CARVE: begin
            if (ctl.remove) begin
               if (ge_s) begin
                  cur_in = next;
               end
            end else if (live && (cur_ff.start == ctl.s)) begin
               cur_in.start = ADDR_W'(cur_ff.start + ctl.l);
               cur_in.len   = ADDR_W'(cur_ff.len - ctl.l);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else begin
         cur_ff <= cur_in;
      end
      sav_ff <= sav_in;
   end

endmodule

`default_nettype wire

FILE: design/fbfa_chain.sv
// Row of free-extent cells, each wired to its two neighbors.
// Depends on fbfa_pkg and fbfa_cell.
`default_nettype none

module fbfa_chain
   import fbfa_pkg::*;
#(
   parameter int CELLS = 48
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   output extent_type        head,
   output logic              any_left,
   output logic              any_right
);

   extent_type   cur [CELLS];
   extent_type   nxt [CELLS];
   extent_type   prv [CELLS];
   logic [CELLS-1:0] gt;
   logic [CELLS-1:0] pgt;
   logic [CELLS-1:0] ml;
   logic [CELLS-1:0] mr;
   cell_ctl_type cctl;

   assign any_left  = |ml;
   assign any_right = |mr;
   assign head      = cur[0];

   always_comb begin
      cctl           = ctl;
      cctl.any_left  = any_left;
      cctl.any_right = any_right;
   end

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prv[i] = '0;
         assign pgt[i] = 1'b0;
      end else begin : g_mid
         assign prv[i] = cur[i-1];
         assign pgt[i] = gt[i-1];
      end
      if (i == CELLS-1) begin : g_last
         // tail wraps to the head only while rotating
         assign nxt[i] = (ctl.op == OP_ROTATE) ? cur[0] : extent_type'('0);
      end else begin : g_body
         assign nxt[i] = cur[i+1];
      end
      fbfa_cell #(.HEAD(i == 0)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (cctl),
         .prev    (prv[i]),
         .next    (nxt[i]),
         .prev_gt (pgt[i]),
         .cur     (cur[i]),
         .gt      (gt[i]),
         .ml      (ml[i]),
         .mr      (mr[i])
      );
   end

endmodule

`default_nettype wire

FILE: tb/first_best_fit_allocator_tb.sv
// Self-checking testbench for first_best_fit_allocator: streams allocate/free
// transactions, predicts each response and compares field by field.
// Depends on fbfa_pkg and the allocator RTL only.
`default_nettype none

module first_best_fit_allocator_tb;
   import fbfa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FREE_SLOTS   = 16;
   localparam int REGION_SLOTS = 32;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int SETTLE_CYCLES = 120;   // longer than one allocate, with margin

   typedef struct {
      action_type  act;
      logic [15:0] owner;
      logic [15:0] bytes;
   } alloc_req_type;

   typedef struct {
      status_type  st;
      logic [15:0] addr;
      logic [15:0] len;
   } alloc_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // owner_id[15:0], request_bytes[31:16]
   logic        req_tuser = 1'b0; // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // status[2:0], start_address[18:3], length[34:19]
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   first_best_fit_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Pool shadow: free extents sorted by address plus the region table.
   // ---------------------------------------------------------------------
   int          pool_size = 1000;
   logic        best_fit  = 1'b0;
   int          ext_start [FREE_SLOTS];
   int          ext_len   [FREE_SLOTS];
   int          ext_cnt;
   logic [15:0] reg_owner [REGION_SLOTS];
   int          reg_start [REGION_SLOTS];
   int          reg_len   [REGION_SLOTS];
   logic        reg_live  [REGION_SLOTS];

   // Memory size write: whole pool back to one extent, all regions dropped.
   function automatic void reload_pool();
      for (int i = 0; i < FREE_SLOTS; i++) begin
         ext_start[i] = 0;
         ext_len[i]   = 0;
      end
      for (int i = 0; i < REGION_SLOTS; i++) reg_live[i] = 1'b0;
      ext_len[0] = pool_size;
      ext_cnt    = (pool_size != 0) ? 1 : 0;
   endfunction

   function automatic alloc_rsp_type grant_region(logic [15:0] owner, int bytes);
      alloc_rsp_type r;
      int slot, pick;
      logic found;
      r = '{STAT_OK, 16'd0, 16'd0};
      slot  = REGION_SLOTS;
      pick  = 0;
      found = 1'b0;
      if (bytes > pool_size) begin
         r.st = STAT_TOO_LARGE;
         return r;
      end
      if (bytes == 0) begin
         r.st = STAT_NO_FIT;
         return r;
      end
      for (int i = REGION_SLOTS - 1; i >= 0; i--) if (!reg_live[i]) slot = i;
      if (slot == REGION_SLOTS) begin
         r.st = STAT_FULL;
         return r;
      end
      for (int i = 0; i < ext_cnt; i++) begin
         if (ext_len[i] >= bytes && !(found && !best_fit)) begin
            if (!found || ext_len[i] < ext_len[pick]) pick = i;
            found = 1'b1;
         end
      end
      if (!found) begin
         r.st = STAT_NO_FIT;
         return r;
      end
      reg_live[slot]  = 1'b1;
      reg_owner[slot] = owner;
      reg_start[slot] = ext_start[pick];
      reg_len[slot]   = bytes;
      ext_start[pick] = (ext_start[pick] + bytes) & 16'hFFFF;
      ext_len[pick]  -= bytes;
      // exhausted extent: close the gap
      if (ext_len[pick] == 0) begin
         for (int i = pick; i + 1 < ext_cnt; i++) begin
            ext_start[i] = ext_start[i+1];
            ext_len[i]   = ext_len[i+1];
         end
         ext_cnt--;
         ext_start[ext_cnt] = 0;
         ext_len[ext_cnt]   = 0;
      end
      r.addr = 16'(reg_start[slot]);
      r.len  = 16'(bytes);
      return r;
   endfunction

   function automatic alloc_rsp_type release_owner(logic [15:0] owner);
      alloc_rsp_type r;
      int ws [FREE_SLOTS + REGION_SLOTS];
      int wl [FREE_SLOTS + REGION_SLOTS];
      int n, m, total, j, s, l;
      logic any;
      r = '{STAT_OK, 16'd0, 16'd0};
      n = 0;
      total = 0;
      any = 1'b0;
      for (int i = 0; i < ext_cnt; i++) begin
         ws[n] = ext_start[i];
         wl[n] = ext_len[i];
         n++;
      end
      for (int i = 0; i < REGION_SLOTS; i++) begin
         if (reg_live[i] && reg_owner[i] == owner) begin
            any = 1'b1;
            total += reg_len[i];
            ws[n] = reg_start[i];
            wl[n] = reg_len[i];
            n++;
         end
      end
      if (!any) begin
         r.st = STAT_NOT_FOUND;
         return r;
      end
      for (int i = 1; i < n; i++) begin
         s = ws[i];
         l = wl[i];
         j = i;
         while (j > 0 && ws[j-1] > s) begin
            ws[j] = ws[j-1];
            wl[j] = wl[j-1];
            j--;
         end
         ws[j] = s;
         wl[j] = l;
      end
      m = 0;
      for (int i = 0; i < n; i++) begin
         if (wl[i] != 0) begin
            if (m > 0 && ws[m-1] + wl[m-1] == ws[i]) begin
               wl[m-1] += wl[i];
            end else begin
               ws[m] = ws[i];
               wl[m] = wl[i];
               m++;
            end
         end
      end
      // too many extents after merging: nothing released
      if (m > FREE_SLOTS) begin
         r.st = STAT_FULL;
         return r;
      end
      for (int i = 0; i < REGION_SLOTS; i++)
         if (reg_live[i] && reg_owner[i] == owner) reg_live[i] = 1'b0;
      for (int i = 0; i < FREE_SLOTS; i++) begin
         ext_start[i] = (i < m) ? (ws[i] & 16'hFFFF) : 0;
         ext_len[i]   = (i < m) ? (wl[i] & 16'hFFFF) : 0;
      end
      ext_cnt = m;
      r.len = 16'(total);
      return r;
   endfunction

   function automatic alloc_rsp_type serve_request(alloc_req_type it);
      if (it.act == ACT_ALLOC) return grant_region(it.owner, int'(it.bytes));
      return release_owner(it.owner);
   endfunction

   // ---------------------------------------------------------------------
   // Shared bookkeeping
   // ---------------------------------------------------------------------
   alloc_req_type pend_q[$];       // not yet offered
   alloc_rsp_type resp_q[$];       // predicted, awaiting the response channel
   alloc_req_type cur_item;
   int  accepted_cnt = 0;
   int  resp_cnt     = 0;
   int  mismatch_cnt = 0;
   int  status_hits [5];
   int  send_idle_pct;
   int  recv_idle_pct;
   int  hold_left = 0;
   logic hold_kick = 1'b0;
   longint cycle_cnt = 0;

   // Idle profile by progress: receiver-heavy, then sender-heavy, then none.
   always_comb begin
      if (accepted_cnt < 480) begin
         send_idle_pct = 37;
         recv_idle_pct = 85;
      end else if (accepted_cnt < 960) begin
         send_idle_pct = 85;
         recv_idle_pct = 37;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   // Request driver: prediction is taken at the accepting edge.
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            resp_q.push_back(serve_request(cur_item));
            accepted_cnt++;
            next_valid = 1'b0;
         end
         if (!next_valid && pend_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_item   = pend_q.pop_front();
            req_tdata  <= {cur_item.bytes, cur_item.owner};
            req_tuser  <= cur_item.act;
            next_valid = 1'b1;
         end
         req_tvalid <= next_valid;
      end
   end

   // Long receiver hold-off, kicked once from the sequence.
   always @(posedge clock) begin
      if (hold_kick) hold_left <= 600;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      alloc_rsp_type want;
      logic [2:0]  got_st;
      logic [15:0] got_addr, got_len;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_st   = rsp_tdata[2:0];
            got_addr = rsp_tdata[18:3];
            got_len  = rsp_tdata[34:19];
            resp_cnt++;
            if (resp_q.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("ERROR: unexpected response transaction, status %0d", got_st);
            end else begin
               want = resp_q.pop_front();
               status_hits[want.st]++;
               if (got_st !== want.st || got_addr !== want.addr || got_len !== want.len) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display("ERROR: response %0d: exp st=%0d addr=%0d len=%0d, got st=%0d addr=%0d len=%0d",
                              resp_cnt, want.st, want.addr, want.len, got_st, got_addr, got_len);
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("ERROR: timeout with %0d responses outstanding", resp_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   task automatic add_req(action_type act, logic [15:0] owner, logic [15:0] bytes);
      alloc_req_type it;
      it.act   = act;
      it.owner = owner;
      it.bytes = bytes;
      pend_q.push_back(it);
   endtask

   // Everything offered, accepted and answered.
   task automatic drain();
      do @(negedge clock);
      while (pend_q.size() != 0 || req_tvalid || resp_q.size() != 0);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_MEMORY_SIZE) begin
         pool_size = int'(value);
         reload_pool();
      end else begin
         best_fit = value[0];
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Fill every region slot with 1-byte regions of two interleaved owners,
   // overflow the table, then free one owner (too many holes), the other, and the first again.
   task automatic add_fill(logic [15:0] own_a, logic [15:0] own_b);
      for (int i = 0; i < REGION_SLOTS; i++) add_req(ACT_ALLOC, i[0] ? own_b : own_a, 16'd1);
      add_req(ACT_ALLOC, own_a, 16'd1);
      add_req(ACT_FREE, own_a, 16'($urandom));
      add_req(ACT_FREE, own_b, 16'($urandom));
      add_req(ACT_FREE, own_a, 16'd0);
   endtask

   task automatic add_random(int count, int max_bytes);
      logic [15:0] owners [8];
      int roll, hi;
      owners[0] = 16'h0000;
      owners[1] = 16'hFFFF;
      for (int i = 2; i < 8; i++) owners[i] = 16'($urandom);
      hi = (max_bytes < 1) ? 1 : max_bytes;
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(99);
         if (roll < 55) begin
            add_req(ACT_ALLOC, owners[$urandom_range(7)],
                    16'($urandom_range(1, (hi / 6 > 1) ? hi / 6 : 1)));
         end else if (roll < 62) begin
            add_req(ACT_ALLOC, owners[$urandom_range(7)], 16'($urandom_range(1, hi)));
         end else if (roll < 66) begin
            // noise: arbitrary sizes, zero included
            add_req(ACT_ALLOC, 16'($urandom), 16'($urandom));
         end else if (roll < 95) begin
            add_req(ACT_FREE, owners[$urandom_range(7)], 16'($urandom));
         end else begin
            add_req(ACT_FREE, 16'($urandom), 16'($urandom));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < 5; i++) status_hits[i] = 0;
      pool_size = 1000;
      best_fit  = 1'b0;
      reload_pool();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (!req_tready);

      // Directed: reset pool of 1000 bytes, first fit.
      add_req(ACT_ALLOC, 16'h0000, 16'd0);       // zero request
      add_req(ACT_ALLOC, 16'h0000, 16'hFFFF);    // too large
      add_req(ACT_FREE,  16'h0001, 16'd5);       // unknown owner
      add_req(ACT_ALLOC, 16'h0001, 16'd1000);    // whole pool, extent vanishes
      add_req(ACT_ALLOC, 16'h0002, 16'd1);       // nothing left
      add_req(ACT_FREE,  16'h0001, 16'h0000);
      add_req(ACT_ALLOC, 16'hFFFF, 16'd100);
      add_req(ACT_ALLOC, 16'h0000, 16'd200);
      add_req(ACT_ALLOC, 16'hFFFF, 16'd300);
      add_req(ACT_FREE,  16'h0000, 16'hFFFF);    // hole at 100
      add_req(ACT_ALLOC, 16'h0005, 16'd150);     // first fit lands in hole
      add_req(ACT_ALLOC, 16'h0006, 16'd50);      // exhausts the hole
      add_req(ACT_ALLOC, 16'h0007, 16'd401);     // tail is 400: no fit
      add_req(ACT_ALLOC, 16'h0007, 16'd400);
      add_req(ACT_FREE,  16'hFFFF, 16'd0);       // two regions released
      add_req(ACT_ALLOC, 16'h5555, 16'hAAAA);
      add_req(ACT_ALLOC, 16'hAAAA, 16'h5555);
      add_req(ACT_FREE,  16'h0005, 16'd0);
      add_req(ACT_FREE,  16'h0006, 16'd0);
      add_req(ACT_FREE,  16'h0007, 16'd0);
      add_req(ACT_FREE,  16'h0007, 16'd0);       // already gone
      add_random(150, 1000);

      // Receiver holds off while the sender keeps offering.
      @(posedge clock);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
      add_random(60, 1000);

      write_csr(CSR_FIT_STRATEGY, 16'd1);
      write_csr(CSR_MEMORY_SIZE, 16'd300);
      add_random(190, 300);
      drain();                                   // sender pause until all answered
      add_random(40, 300);

      write_csr(CSR_MEMORY_SIZE, 16'd65535);
      add_fill(16'h1234, 16'hEDCB);
      add_random(190, 65535);

      write_csr(CSR_FIT_STRATEGY, 16'd0);
      write_csr(CSR_MEMORY_SIZE, 16'd1);
      add_random(100, 1);

      write_csr(CSR_MEMORY_SIZE, 16'd0);
      add_random(40, 2);

      write_csr(CSR_MEMORY_SIZE, 16'd4096);
      add_fill(16'h0000, 16'hFFFF);
      add_random(190, 4096);

      write_csr(CSR_FIT_STRATEGY, 16'd1);
      write_csr(CSR_MEMORY_SIZE, 16'd64);
      add_random(190, 64);

      write_csr(CSR_MEMORY_SIZE, 16'd65535);
      add_random(160, 65535);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d requests over several pool sizes and both fit strategies.",
               accepted_cnt);
      $display("Statuses seen: ok %0d, too large %0d, no fit %0d, not found %0d, full %0d.",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
      if (mismatch_cnt == 0 && resp_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", mismatch_cnt);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
